@@ src/integer_deque_with_search_defines.svh @@
// Assertion macros shared by the integer deque design files.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef INTEGER_DEQUE_WITH_SEARCH_DEFINES_SVH
`define INTEGER_DEQUE_WITH_SEARCH_DEFINES_SVH

// Checked on every clock edge, ignored while reset is asserted.
`define DQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/idq_pkg.sv @@
// Package for the integer deque with search: request types, codes and defaults.
// Used by idq_cell and integer_deque_with_search; depends on nothing.
package idq_pkg;

    // Default number of cells in the chain.
    localparam int DEPTH_DEF = 16;

    // Command codes; the two unused codes are no-ops.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_COUNT      = 3'd4,
        OP_SEARCH     = 3'd5
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Input request payload.
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } t_in_req;

    // Output request payload.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [4:0]         position;
        logic [4:0]         occupancy;
    } t_out_req;

    // Update controls broadcast from the top level to every cell.
    typedef struct packed {
        logic               shift_right;
        logic               shift_left;
        logic               write_tail;
        logic signed [31:0] value;
    } t_cell_ctrl;

endpackage

@@ src/idq_cell.sv @@
// One cell of the deque chain: holds the entry at a fixed position from the front.
// Depends on idq_pkg for the broadcast control struct.
module idq_cell
    import idq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                                i_clk,
    input  t_cell_ctrl                          i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]          i_count,
    input  logic signed [31:0]                  i_left_data,
    input  logic signed [31:0]                  i_right_data,
    output logic signed [31:0]                  o_data,
    output logic                                o_match,
    output logic signed [31:0]                  o_last_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] L_IDX  = CW'(IDX);
    localparam logic [CW-1:0] L_NEXT = CW'(IDX + 1);

    logic signed [31:0] r_data;
    logic               w_live;
    logic               w_tail;
    logic               w_last;

    // Position of this cell relative to the current fill level.
    assign w_live = (L_IDX < i_count);
    assign w_tail = (i_count == L_IDX);
    assign w_last = (i_count == L_NEXT);

    // Entry storage: shift toward the back, shift toward the front, or take a back push.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_right) begin
            r_data <= i_left_data;
        end else if (i_ctrl.shift_left) begin
            r_data <= i_right_data;
        end else if (i_ctrl.write_tail && w_tail) begin
            r_data <= i_ctrl.value;
        end
    end

    // Local compare for search and contribution to the back-pop read.
    assign o_data      = r_data;
    assign o_match     = w_live && (r_data == i_ctrl.value);
    assign o_last_data = w_last ? r_data : 32'sd0;

endmodule

@@ src/integer_deque_with_search.sv @@
// Integer deque with search: a chain of DEPTH cells, front entry in cell zero.
// Result: registered; it appears in the cycle after its command request is accepted.
// Throughput: one command per cycle while the output side is ready, set by the cell update and
// the per-cell compare feeding a priority encoder; the output register holds a result while stalled.
// Reset: synchronous active-low; empties the deque, entry contents stay undefined.
`include "integer_deque_with_search_defines.svh"

module integer_deque_with_search
    import idq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] L_DEPTH = CW'(DEPTH);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    t_out_req           r_out;
    t_out_req           n_out;
    logic               w_in_acc;
    logic               w_full;
    logic               w_empty;
    t_cell_ctrl         w_ctrl;
    logic signed [31:0] w_data      [DEPTH];
    logic signed [31:0] w_last_data [DEPTH];
    logic [DEPTH-1:0]   w_match;
    logic signed [31:0] w_back_data;
    logic [CW-1:0]      w_pos;
    logic               w_found;

    // Handshake: take a new request whenever the output register is free or draining.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_full  = (r_count == L_DEPTH);
    assign w_empty = (r_count == '0);

    // Broadcast controls to the cell chain.
    always_comb begin
        w_ctrl.shift_right = w_in_acc && (t_opcode'(i_in.opcode) == OP_PUSH_FRONT) && !w_full;
        w_ctrl.write_tail  = w_in_acc && (t_opcode'(i_in.opcode) == OP_PUSH_BACK) && !w_full;
        w_ctrl.shift_left  = w_in_acc && (t_opcode'(i_in.opcode) == OP_POP_FRONT) && !w_empty;
        w_ctrl.value       = i_in.value;
    end

    // The chain of cells; cell zero takes the pushed value from the left.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_in.value;
        end else begin : g_mid_left
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_right = 32'sd0;
        end else begin : g_mid_right
            assign w_right = w_data[g+1];
        end
        idq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_count      (r_count),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_data       (w_data[g]),
            .o_match      (w_match[g]),
            .o_last_data  (w_last_data[g])
        );
    end

    // Back entry: at most one cell, the one holding the back entry, drives its data; all others drive zero.
    always_comb begin
        w_back_data = 32'sd0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_data = w_back_data | w_last_data[i];
        end
    end

    // Priority encoder: first matching cell from the front, 1-based.
    always_comb begin
        w_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_pos = CW'(i + 1);
            end
        end
    end
    assign w_found = |w_match;

    // Result and next fill level for the accepted command.
    always_comb begin
        n_count        = r_count;
        n_out.status   = ST_OK;
        n_out.data     = 32'sd0;
        n_out.position = 5'd0;
        case (t_opcode'(i_in.opcode))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.data = w_data[0];
                    n_count    = r_count - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.data = w_back_data;
                    n_count    = r_count - CW'(1);
                end
            end
            OP_COUNT: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end
            end
            OP_SEARCH: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else if (w_found) begin
                    n_out.data     = i_in.value;
                    n_out.position = 5'(w_pos);
                end else begin
                    n_out.status = ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
        n_out.occupancy = 5'(n_count);
    end

    // Fill level and output handshake state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    // Checks on fill tracking and result consistency.
    `DQ_ASSERT(a_count_bound, r_count <= L_DEPTH, "fill level exceeds depth")
    `DQ_ASSERT(a_push_grows, (w_in_acc && !w_full && (t_opcode'(i_in.opcode) == OP_PUSH_BACK || t_opcode'(i_in.opcode) == OP_PUSH_FRONT)) |=> (r_count == $past(r_count) + CW'(1)), "push did not grow the deque")
    `DQ_ASSERT(a_result_follows, w_in_acc |=> r_out_valid, "accepted request produced no result")
    `DQ_ASSERT(a_pos_in_range, (r_out_valid && r_out.position != 5'd0) |-> (r_out.status == ST_OK), "match position with non-ok status")

endmodule
